// ----- design/nwl_pkg.sv -----
// Package for the nearest waypoint lookahead block: field widths, codes,
// payload structs and the controller state type.
// No dependencies.
package nwl_pkg;

    // Coordinate width is fixed by the payload structs.
    localparam int COORD_BITS = 24;
    localparam int TABLE_DEPTH_DEFAULT = 1024;

    // Result field widths.
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;

    // Squared distance: each square fits 2*COORD_BITS, their sum one more bit.
    localparam int SQ_W = 2 * COORD_BITS;
    localparam int DIST_W = SQ_W + 1;

    // Input item kinds.
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Input transfer payload.
    typedef struct packed {
        logic [1:0]                   kind;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic [COORD_BITS-1:0]        lookahead;
    } nwl_in_t;

    // Result transfer payload.
    typedef struct packed {
        logic [1:0]         status;
        logic [INDEX_W-1:0] closest_index;
        logic [COUNT_W-1:0] run_count;
    } nwl_out_t;

    // One stored path point.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } nwl_point_t;

    // Query controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RUN,
        ST_DONE
    } nwl_state_t;

endpackage

// ----- design/nwl_dist_pipe.sv -----
// Three-stage squared distance pipeline: absolute differences, squares, sum.
// Depends on nwl_pkg.
module nwl_dist_pipe
    import nwl_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    input  nwl_point_t                   in_point,
    input  logic signed [COORD_BITS-1:0] ego_x,
    input  logic signed [COORD_BITS-1:0] ego_y,
    output logic                         out_valid,
    output logic [DIST_W-1:0]            out_dist,
    output logic                         busy
);

    logic signed [COORD_BITS:0] diff_x;
    logic signed [COORD_BITS:0] diff_y;
    logic [COORD_BITS-1:0]      abs_x;
    logic [COORD_BITS-1:0]      abs_y;

    logic                  v1_reg;
    logic                  v2_reg;
    logic                  v3_reg;
    logic [COORD_BITS-1:0] dx_reg;
    logic [COORD_BITS-1:0] dy_reg;
    logic [SQ_W-1:0]       sqx_reg;
    logic [SQ_W-1:0]       sqy_reg;
    logic [DIST_W-1:0]     dist_reg;

    // Differences one bit wider than the coordinates; the magnitude always
    // fits back into COORD_BITS bits.
    assign diff_x = {in_point.x[COORD_BITS-1], in_point.x} - {ego_x[COORD_BITS-1], ego_x};
    assign diff_y = {in_point.y[COORD_BITS-1], in_point.y} - {ego_y[COORD_BITS-1], ego_y};
    assign abs_x  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
    assign abs_y  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Datapath: magnitudes, then squares, then their sum.
    always_ff @(posedge aclk) begin
        dx_reg   <= abs_x;
        dy_reg   <= abs_y;
        sqx_reg  <= dx_reg * dx_reg;
        sqy_reg  <= dy_reg * dy_reg;
        dist_reg <= DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
    end

    assign out_valid = v3_reg;
    assign out_dist  = dist_reg;
    assign busy      = v1_reg | v2_reg | v3_reg;

endmodule

// ----- design/nearest_waypoint_lookahead_top.sv -----
// Clear, append, the unused kind and a query on an empty table are answered directly. A query
// on N points scans all N for the nearest one, then counts the run of points from it that lie
// within the lookahead, ending at the last point or the first point outside: one memory read
// per cycle into the read register and the distance pipeline, drained after scan and run.
// Throughput: one item at a time, the next taken once the result register is free (short
// items can follow one per cycle). Reset (synchronous, active low) empties the table, sends
// the controller back to idle and drops a waiting result.
// Top level: point memory, point count, query controller and result register.
// Depends on nwl_pkg and nwl_dist_pipe.
module nearest_waypoint_lookahead_top
    import nwl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  nwl_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output nwl_out_t m_data
);

    localparam int IDXW = $clog2(TABLE_DEPTH);
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);

    nwl_state_t state_reg;
    nwl_state_t state_next;

    nwl_point_t point_mem [TABLE_DEPTH];
    nwl_point_t rd_data_reg;
    logic       rd_valid_reg;

    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] issue_ptr_reg;
    logic [CNTW-1:0] tail_idx_reg;
    logic [CNTW-1:0] best_idx_reg;
    logic [CNTW-1:0] run_reg;
    logic            stopped_reg;
    logic [DIST_W-1:0] best_dist_reg;

    logic signed [COORD_BITS-1:0] ego_x_reg;
    logic signed [COORD_BITS-1:0] ego_y_reg;
    logic [SQ_W-1:0]              limit_reg;

    logic     m_valid_reg;
    nwl_out_t m_data_reg;

    logic              out_free;
    logic              accept;
    logic              start_query;
    logic              imm_resp;
    logic              issue_en;
    logic              scan_done;
    logic              run_done;
    logic              load_resp;
    logic              table_full;
    logic              pipe_valid;
    logic [DIST_W-1:0] pipe_dist;
    logic              pipe_busy;
    logic              busy;
    logic              issue_left;

    // Handshake and status terms shared by the blocks below.
    assign out_free    = !m_valid_reg || m_ready;
    assign accept      = s_valid && s_ready;
    assign table_full  = (count_reg == CNTW'(TABLE_DEPTH));
    assign start_query = accept && (s_data.kind == KIND_QUERY) && (count_reg != '0);
    assign imm_resp    = accept && !start_query;
    assign busy        = rd_valid_reg | pipe_busy;
    assign issue_left  = (issue_ptr_reg < count_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_query) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_done) state_next = ST_RUN;
            end
            ST_RUN: begin
                if (run_done) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb begin
        s_ready   = 1'b0;
        issue_en  = 1'b0;
        scan_done = 1'b0;
        run_done  = 1'b0;
        load_resp = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = out_free;
            end
            ST_SCAN: begin
                issue_en  = issue_left;
                scan_done = !issue_left && !busy;
            end
            ST_RUN: begin
                issue_en = issue_left && !stopped_reg;
                run_done = (stopped_reg || !issue_left) && !busy;
            end
            ST_DONE: begin
                load_resp = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Point memory: append writes at the fill count, the scan and the run read one entry a cycle.
    always_ff @(posedge aclk) begin
        if (accept && (s_data.kind == KIND_APPEND) && !table_full) begin
            point_mem[count_reg[IDXW-1:0]] <= '{x: s_data.coord_x, y: s_data.coord_y};
        end
        if (issue_en) begin
            rd_data_reg <= point_mem[issue_ptr_reg[IDXW-1:0]];
        end
    end

    // Fill count and read-valid tag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= issue_en;
            if (accept && (s_data.kind == KIND_CLEAR)) begin
                count_reg <= '0;
            end else if (accept && (s_data.kind == KIND_APPEND) && !table_full) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Query operands, captured with the transfer.
    always_ff @(posedge aclk) begin
        if (accept) begin
            ego_x_reg <= s_data.coord_x;
            ego_y_reg <= s_data.coord_y;
            limit_reg <= s_data.lookahead * s_data.lookahead;
        end
    end

    nwl_dist_pipe u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rd_valid_reg),
        .in_point  (rd_data_reg),
        .ego_x     (ego_x_reg),
        .ego_y     (ego_y_reg),
        .out_valid (pipe_valid),
        .out_dist  (pipe_dist),
        .busy      (pipe_busy)
    );

    // Scan bookkeeping: minimum search, then the run from the nearest point.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_ptr_reg <= '0;
            tail_idx_reg  <= '0;
            best_idx_reg  <= '0;
            run_reg       <= '0;
            stopped_reg   <= 1'b0;
        end else begin
            if (start_query) begin
                issue_ptr_reg <= '0;
                tail_idx_reg  <= '0;
                best_idx_reg  <= '0;
            end else if (scan_done) begin
                issue_ptr_reg <= best_idx_reg;
                run_reg       <= '0;
                stopped_reg   <= 1'b0;
            end else if (issue_en) begin
                issue_ptr_reg <= issue_ptr_reg + 1'b1;
            end

            // The first point always wins; later ones only when strictly nearer.
            if ((state_reg == ST_SCAN) && pipe_valid) begin
                tail_idx_reg <= tail_idx_reg + 1'b1;
                if ((tail_idx_reg == '0) || (pipe_dist < best_dist_reg)) begin
                    best_idx_reg <= tail_idx_reg;
                end
            end

            // Count points within the lookahead until the first one outside it.
            if ((state_reg == ST_RUN) && pipe_valid && !stopped_reg) begin
                if (pipe_dist <= DIST_W'(limit_reg)) begin
                    run_reg <= run_reg + 1'b1;
                end else begin
                    stopped_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_SCAN) && pipe_valid &&
            ((tail_idx_reg == '0) || (pipe_dist < best_dist_reg))) begin
            best_dist_reg <= pipe_dist;
        end
    end

    // Result register: a waiting result holds off the next input transfer until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (imm_resp || load_resp) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (imm_resp) begin
            m_data_reg.status        <= STATUS_OK;
            m_data_reg.closest_index <= '0;
            m_data_reg.run_count     <= '0;
            if ((s_data.kind == KIND_APPEND) && table_full) begin
                m_data_reg.status <= STATUS_FULL;
            end else if (s_data.kind == KIND_QUERY) begin
                m_data_reg.status <= STATUS_EMPTY;
            end
        end else if (load_resp) begin
            m_data_reg.status        <= STATUS_OK;
            m_data_reg.closest_index <= INDEX_W'(best_idx_reg);
            m_data_reg.run_count     <= COUNT_W'(run_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The fill count never passes the table depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNTW'(TABLE_DEPTH))
        else $error("point count above table depth");

    // While a query is worked on, the read pointer never runs past the stored points.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (issue_ptr_reg <= count_reg))
        else $error("read pointer beyond point count");

    // The nearest point found is always a stored one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (best_idx_reg < count_reg))
        else $error("nearest index outside the table");

    // An input transfer never overwrites a result that has not been taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> out_free)
        else $error("input accepted while result register is held");

    // A query on a non-empty table starts the scan on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        start_query |=> (state_reg == ST_SCAN))
        else $error("query did not start a scan");

endmodule
